### hw/rtl/kgrr_pkg.sv
// Shared types and constants for the k-group reverse reorder block.
// Used by every module in hw/rtl; depends on nothing else.
package kgrr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int IDX_W     = $clog2(MAX_GROUP);
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int DATA_W    = 32;
   localparam int GSIZE_W   = 5;

   localparam logic [GSIZE_W-1:0] GROUP_SIZE_RESET = GSIZE_W'(2);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_list;
   } kgrr_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     run_last;
      logic                     list_last;
   } kgrr_rsp_type;

   // Buffer access from the sequencer: one write port, one read port.
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } kgrr_mem_req_type;

   typedef struct packed {
      logic run_last;
      logic list_last;
   } kgrr_flags_type;

endpackage

### hw/rtl/kgrr_buffer.sv
// Group buffer: MAX_GROUP x DATA_W synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued. Uses kgrr_pkg.
module kgrr_buffer (
   input  logic                          clock,
   input  kgrr_pkg::kgrr_mem_req_type    mem_req,
   output logic [kgrr_pkg::DATA_W-1:0]   rdata
);

   logic [kgrr_pkg::DATA_W-1:0] buf_ff [kgrr_pkg::MAX_GROUP];
   logic [kgrr_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         buf_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= buf_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/kgrr_ctrl.sv
// Sequencer: stores requests into the group buffer and walks it out when a
// group closes. Holds the group size register. Uses kgrr_pkg.
module kgrr_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kgrr_pkg::kgrr_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output kgrr_pkg::kgrr_flags_type          rsp_flags,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kgrr_pkg::GSIZE_W-1:0]      csr_wdata,
   output kgrr_pkg::kgrr_mem_req_type        mem_req
);

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_SHOW} state_type;

   state_type                       state_ff, state_in;
   logic [kgrr_pkg::GSIZE_W-1:0]    gsize_ff, gsize_in;
   logic [kgrr_pkg::IDX_W-1:0]      fill_ff, fill_in;
   logic [kgrr_pkg::IDX_W-1:0]      last_ff, last_in;
   logic [kgrr_pkg::IDX_W-1:0]      pos_ff, pos_in;
   logic                            rev_ff, rev_in;
   logic                            end_ff, end_in;

   logic [kgrr_pkg::CNT_W-1:0]      eff_k;
   logic [kgrr_pkg::CNT_W-1:0]      count;
   logic                            req_fire;
   logic                            rsp_fire;
   logic                            at_last;
   logic [kgrr_pkg::IDX_W-1:0]      rd_pos;

   // Zero acts as pass through, oversize saturates to the buffer depth.
   always_comb begin
      if (gsize_ff == '0) begin
         eff_k = kgrr_pkg::CNT_W'(1);
      end else if (int'(gsize_ff) > kgrr_pkg::MAX_GROUP) begin
         eff_k = kgrr_pkg::CNT_W'(kgrr_pkg::MAX_GROUP);
      end else begin
         eff_k = kgrr_pkg::CNT_W'(gsize_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign count     = kgrr_pkg::CNT_W'(fill_ff) + kgrr_pkg::CNT_W'(1);
   assign at_last   = (pos_ff == last_ff);

   assign rsp_flags.run_last  = at_last;
   assign rsp_flags.list_last = at_last && end_ff;

   // Position to read: first entry on issue, the following one on each take.
   assign rd_pos = (state_ff == ST_ISSUE) ? pos_ff : pos_ff + kgrr_pkg::IDX_W'(1);

   always_comb begin
      mem_req.we    = req_fire;
      mem_req.waddr = fill_ff;
      mem_req.wdata = req_data.value;
      mem_req.re    = (state_ff == ST_ISSUE) || (rsp_fire && !at_last);
      mem_req.raddr = rev_ff ? last_ff - rd_pos : rd_pos;
   end

   always_comb begin
      state_in = state_ff;
      gsize_in = gsize_ff;
      fill_in  = fill_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      rev_in   = rev_ff;
      end_in   = end_ff;
      if (csr_valid && csr_ready) begin
         gsize_in = csr_wdata;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count >= eff_k || req_data.end_of_list) begin
                  // Close the group: walk it out, reversed only if full.
                  last_in  = fill_ff;
                  pos_in   = '0;
                  rev_in   = (count >= eff_k);
                  end_in   = req_data.end_of_list;
                  fill_in  = '0;
                  state_in = ST_ISSUE;
               end else begin
                  fill_in = kgrr_pkg::IDX_W'(count);
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_fire) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = rd_pos;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gsize_ff <= kgrr_pkg::GROUP_SIZE_RESET;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         gsize_ff <= gsize_in;
         fill_ff  <= fill_in;
      end
      last_ff <= last_in;
      pos_ff  <= pos_in;
      rev_ff  <= rev_in;
      end_ff  <= end_in;
   end

endmodule

### hw/rtl/k_group_reverse_reorder.sv
// Top level of the k-group reverse reorder block.
// Instantiates kgrr_ctrl and kgrr_buffer; uses kgrr_pkg.
//
//   channel   ports                               direction
//   request   req_valid/req_ready/req_data        in
//   result    rsp_valid/rsp_ready/rsp_data        out
//   config    csr_valid/csr_ready/csr_wdata       in (group size)
//
// A request that does not close a group is accepted and leaves the block ready.
// A request that closes a group of n values is accepted, then the ISSUE state
// makes the first buffer read, then one result follows per cycle while
// rsp_ready is high. The single read port of the group buffer sets this pace.
// Reset clears the fill count and loads group size 2; the buffer is not cleared.
// A stalled result holds in the buffer read register; requests wait meanwhile.
module k_group_reverse_reorder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kgrr_pkg::kgrr_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kgrr_pkg::kgrr_rsp_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kgrr_pkg::GSIZE_W-1:0]  csr_wdata
);

   kgrr_pkg::kgrr_mem_req_type   mem_req;
   kgrr_pkg::kgrr_flags_type     rsp_flags;
   logic [kgrr_pkg::DATA_W-1:0]  rdata;

   kgrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_flags (rsp_flags),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req)
   );

   kgrr_buffer u_buffer (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   assign rsp_data.out_value = rdata;
   assign rsp_data.run_last  = rsp_flags.run_last;
   assign rsp_data.list_last = rsp_flags.list_last;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_list_implies_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.list_last || rsp_data.run_last))
      else $error("list_last without run_last");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.run_last) |=> (req_ready && !rsp_valid))
      else $error("not ready for requests after the last result of a run");

   a_first_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_list) |=> (!req_ready && !rsp_valid))
      else $error("end of list did not start a buffer read");

endmodule

### tb/tb_k_group_reverse_reorder.sv
// Testbench for k_group_reverse_reorder: drives lists of values under a fixed list of group sizes,
// predicts the reversed groups and checks every result.
// Depends on kgrr_pkg and the k_group_reverse_reorder top level.
`timescale 1ns / 100ps

module tb_k_group_reverse_reorder;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 11;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   kgrr_pkg::kgrr_req_type        req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   kgrr_pkg::kgrr_rsp_type        rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [kgrr_pkg::GSIZE_W-1:0]  csr_wdata = '0;

   // Model state of the block
   logic [kgrr_pkg::DATA_W-1:0]   held_values [kgrr_pkg::MAX_GROUP];
   int                            held_count = 0;
   logic [kgrr_pkg::GSIZE_W-1:0]  group_size_reg = kgrr_pkg::GROUP_SIZE_RESET;

   kgrr_pkg::kgrr_req_type        list_items [$];
   kgrr_pkg::kgrr_rsp_type        reordered_values [$];
   int                            n_queued = 0;
   int                            n_accepted = 0;
   int                            errors = 0;
   int                            hold_requests = 0;
   int                            hold_served = 0;
   int                            req_gap = 0;
   int                            rsp_stall = 0;
   int                            rsp_hold = 0;
   int                            idle_cycles = 0;
   logic                          steady = 1'b0;
   int                            phase_sizes [NUM_PHASES] =
                                     '{16, 3, 1, 31, 5, 0, 2, 17, 7, 4, 15, 9};

   k_group_reverse_reorder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_size(input logic [kgrr_pkg::GSIZE_W-1:0] raw);
      int k;
      k = raw;
      if (k == 0) k = 1;
      if (k > kgrr_pkg::MAX_GROUP) k = kgrr_pkg::MAX_GROUP;
      return k;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) return 0;
      else if (roll < 90) return $urandom_range(3, 1);
      else if (roll < 98) return $urandom_range(10, 4);
      else return $urandom_range(60, 20);
   endfunction

   function automatic logic [kgrr_pkg::DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 3) return 32'h8000_0000;
      else if (roll < 6) return 32'h7FFF_FFFF;
      else if (roll < 8) return 32'h0000_0000;
      else if (roll < 10) return 32'hFFFF_FFFF;
      else return $urandom();
   endfunction

   // Collect one value; emit a full group reversed, or a partial group in order on end mark.
   task automatic reverse_groups(input kgrr_pkg::kgrr_req_type item);
      kgrr_pkg::kgrr_rsp_type r;
      int k;
      int n;
      k = clamp_size(group_size_reg);
      if (held_count >= kgrr_pkg::MAX_GROUP) held_count = kgrr_pkg::MAX_GROUP - 1;
      held_values[held_count] = item.value;
      held_count++;
      n = held_count;
      if (n >= k) begin
         for (int i = 0; i < n; i++) begin
            r.out_value = held_values[n - 1 - i];
            r.run_last  = (i == n - 1);
            r.list_last = (i == n - 1) && item.end_of_list;
            reordered_values.push_back(r);
         end
         held_count = 0;
      end else if (item.end_of_list) begin
         for (int i = 0; i < n; i++) begin
            r.out_value = held_values[i];
            r.run_last  = (i == n - 1);
            r.list_last = (i == n - 1);
            reordered_values.push_back(r);
         end
         held_count = 0;
      end
   endtask

   task automatic push_item(input logic [kgrr_pkg::DATA_W-1:0] v, input logic eol);
      kgrr_pkg::kgrr_req_type item;
      item.value       = v;
      item.end_of_list = eol;
      list_items.push_back(item);
      n_queued++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (n_accepted != n_queued || reordered_values.size() != 0);
   endtask

   // Write the group size only once the block has gone quiet.
   task automatic write_group_size(input logic [kgrr_pkg::GSIZE_W-1:0] v);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock);
      while (!csr_ready);
      group_size_reg = v;
      csr_valid <= 1'b0;
   endtask

   // Request driver
   always @(posedge clock) begin
      logic offered;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         offered = req_valid;
         if (req_valid && req_ready) begin
            reverse_groups(req_data);
            n_accepted++;
            offered = 1'b0;
         end
         if (offered) begin
            // hold the request until it is taken
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (list_items.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= list_items.pop_front();
            req_gap = steady ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver stalls
   always @(posedge clock) begin
      kgrr_pkg::kgrr_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reordered_values.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: value %h run_last %b list_last %b",
                           rsp_data.out_value, rsp_data.run_last, rsp_data.list_last);
            end else begin
               want = reordered_values.pop_front();
               if (rsp_data.out_value !== want.out_value ||
                   rsp_data.run_last !== want.run_last ||
                   rsp_data.list_last !== want.list_last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                              want.out_value, want.run_last, want.list_last,
                              rsp_data.out_value, rsp_data.run_last, rsp_data.list_last);
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (hold_served < hold_requests) begin
            hold_served++;
            rsp_hold = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = steady ? 0 : pick_gap();
         end
      end
   end

   // Watchdog: no request, result or register write for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_k_group_reverse_reorder: done, errors");
         $finish;
      end
   end

   initial begin
      int k;
      int len;
      int roll;
      int produced;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset group size of two: extremes, end mark on a completing value, short tail
      push_item(32'h8000_0000, 1'b0);
      push_item(32'h7FFF_FFFF, 1'b0);
      push_item(32'h0000_0000, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b1);
      push_item(32'h0000_0005, 1'b1);

      // Size zero acts as pass through
      write_group_size(5'd0);
      push_item(32'h5555_5555, 1'b0);
      push_item(32'hAAAA_AAAA, 1'b1);

      // Oversized group saturates; a short list comes out in order
      write_group_size(5'd31);
      push_item(32'h0000_0001, 1'b0);
      push_item(32'h0000_0002, 1'b0);
      push_item(32'h0000_0003, 1'b1);

      // Lower the size while a group of eight holds five values
      write_group_size(5'd8);
      for (int i = 0; i < 5; i++) push_item(32'h1000_0000 + i, 1'b0);
      write_group_size(5'd3);
      push_item(32'h2000_0000, 1'b0);

      write_group_size(5'd1);
      push_item(32'h1234_5678, 1'b1);
      push_item(32'h8765_4321, 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_group_size(phase_sizes[p][kgrr_pkg::GSIZE_W-1:0]);
         steady = (p % 4 == 2);
         k = clamp_size(phase_sizes[p][kgrr_pkg::GSIZE_W-1:0]);
         produced = 0;
         while (produced < PHASE_ITEMS) begin
            roll = $urandom_range(99, 0);
            if (roll < 80) begin
               len = $urandom_range(2 * k + 1, 1);
               for (int i = 0; i < len; i++) push_item(pick_value(), i == len - 1);
            end else begin
               // noise: end marks at random
               len = $urandom_range(8, 1);
               for (int i = 0; i < len; i++)
                  push_item(pick_value(), $urandom_range(3, 0) == 0);
            end
            produced += len;
         end
         // sometimes leave a partial group held across the next size change
         if (k > 1 && $urandom_range(1, 0) == 1) begin
            len = $urandom_range(k - 1, 1);
            for (int i = 0; i < len; i++) push_item(pick_value(), 1'b0);
         end
         if (p == 0) hold_requests++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_k_group_reverse_reorder: done, clean");
      else
         $display("tb_k_group_reverse_reorder: done, errors");
      $finish;
   end

endmodule

### files.f
hw/rtl/kgrr_pkg.sv
hw/rtl/kgrr_buffer.sv
hw/rtl/kgrr_ctrl.sv
hw/rtl/k_group_reverse_reorder.sv
tb/tb_k_group_reverse_reorder.sv
